// ----- hdl/wpp_pkg.sv -----
// ----------------------------------------------------------------------------
// wpp_pkg
// shared types, widths and helpers for the world to pixel projection
// ----------------------------------------------------------------------------
package wpp_pkg;

  localparam int ROT_FRAC = 18;
  localparam int CW       = 36;
  localparam int PW       = 68;
  localparam int QW       = 40;
  localparam int NSTEP    = 4;
  localparam int NDIV     = QW / NSTEP;
  localparam int NST      = NDIV + 5;

  typedef enum logic [2:0] {
    REG_ROT0   = 3'd0,
    REG_ROT1   = 3'd1,
    REG_ROT2   = 3'd2,
    REG_SHX    = 3'd3,
    REG_SHY    = 3'd4,
    REG_SHZ    = 3'd5,
    REG_FOCAL  = 3'd6,
    REG_CENTER = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [QW-1:0] low;
    logic          big;
    logic          neg;
    logic [31:0]   c;
  } lane_t;

  typedef struct packed {
    lane_t         u;
    lane_t         v;
    logic [CW-1:0] d;
    logic          front;
  } div_t;

  typedef struct packed {
    logic [PW-1:0] prod;
    logic          neg;
    logic [31:0]   c;
  } prj_t;

  function automatic lane_t div_steps(lane_t a, logic [CW-1:0] d);
    logic [CW:0] t;
    lane_t       r;
    r = a;
    for (int i = 0; i < NSTEP; i++) begin
      t = {r.rem, r.low[QW-1]};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        r.low = {r.low[QW-2:0], 1'b1};
      end else begin
        r.low = {r.low[QW-2:0], 1'b0};
      end
      r.rem = t[CW-1:0];
    end
    return r;
  endfunction

  function automatic lane_t div_init(prj_t p, logic [CW-1:0] d);
    lane_t r;
    r.big = ({{(2*CW+QW-PW){1'b0}}, p.prod[PW-1:QW]} >= {{(CW){1'b0}}, d});
    r.rem = {{(CW-(PW-QW)){1'b0}}, p.prod[PW-1:QW]};
    r.low = p.prod[QW-1:0];
    r.neg = p.neg;
    r.c   = p.c;
    return r;
  endfunction

  // returns {saturated, pixel}
  function automatic logic [32:0] finish(lane_t a);
    logic signed [QW+1:0] sq;
    logic signed [QW+1:0] r;
    logic                 ovf;
    sq  = a.neg ? -$signed({2'b00, a.low}) : $signed({2'b00, a.low});
    r   = sq + $signed({{(QW-30){1'b0}}, a.c});
    ovf = (r[QW+1:31] != {(QW-29){1'b0}}) && (r[QW+1:31] != {(QW-29){1'b1}});
    if (a.big) begin
      return {1'b1, a.neg ? 32'h8000_0000 : 32'h7fff_ffff};
    end else if (ovf) begin
      return {1'b1, r[QW+1] ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return {1'b0, r[31:0]};
  endfunction

endpackage

// ----- hdl/wpp_if.sv -----
// ----------------------------------------------------------------------------
// wpp_if
// point and pixel stream channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface wpp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] world_x;
  logic [31:0] world_y;
  logic [31:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wpp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_u;
  logic [31:0] pixel_v;
  logic        in_front;
  logic        clipped;
  modport source (output valid, pixel_u, pixel_v, in_front, clipped, input ready);
  modport sink   (input valid, pixel_u, pixel_v, in_front, clipped, output ready);
endinterface

// ----- hdl/world_to_pixel_projection.sv -----
// ----------------------------------------------------------------------------
// world_to_pixel_projection
// rigid pose transform and pinhole projection of Q16.16 points
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// in_bus    in   world_x, world_y, world_z
// out_bus   out  pixel_u, pixel_v, in_front, clipped
// apb       in   pose, focal and center registers, 8 byte stride
//
// one beat per cycle sustained while out_bus is ready
// restoring divider: 4 quotient bits per stage, 10 stages
// rst_n is synchronous; registers take pose identity, unit focal, zero center
// a stall only holds filled stages, empty stages keep taking beats
// ----------------------------------------------------------------------------
module world_to_pixel_projection
  import wpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  wpp_in_if.sink      in_bus,
  wpp_out_if.source   out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [59:0] rot_r [3];
  logic [31:0] sh_r [3];
  logic [63:0] focal_r, center_r;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 60'h1 << 58;
      rot_r[1] <= 60'h1 << 38;
      rot_r[2] <= 60'h1 << 18;
      sh_r[0]  <= '0;
      sh_r[1]  <= '0;
      sh_r[2]  <= '0;
      focal_r  <= 64'h0001_0000_0001_0000;
      center_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_ROT0:   rot_r[0] <= pwdata[59:0];
        REG_ROT1:   rot_r[1] <= pwdata[59:0];
        REG_ROT2:   rot_r[2] <= pwdata[59:0];
        REG_SHX:    sh_r[0]  <= pwdata[31:0];
        REG_SHY:    sh_r[1]  <= pwdata[31:0];
        REG_SHZ:    sh_r[2]  <= pwdata[31:0];
        REG_FOCAL:  focal_r  <= pwdata;
        REG_CENTER: center_r <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ROT0:   prdata = {4'h0, rot_r[0]};
      REG_ROT1:   prdata = {4'h0, rot_r[1]};
      REG_ROT2:   prdata = {4'h0, rot_r[2]};
      REG_SHX:    prdata = {32'h0, sh_r[0]};
      REG_SHY:    prdata = {32'h0, sh_r[1]};
      REG_SHZ:    prdata = {32'h0, sh_r[2]};
      REG_FOCAL:  prdata = focal_r;
      REG_CENTER: prdata = center_r;
      default:    prdata = '0;
    endcase
  end

  // stage handshake
  logic [NST-1:0] v_r, en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_bus.ready;
    for (int k = NST-2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_bus.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_bus.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: rotation products
  logic signed [31:0] pt [3];
  logic signed [51:0] m_r [3][3];

  assign pt[0] = $signed(in_bus.world_x);
  assign pt[1] = $signed(in_bus.world_y);
  assign pt[2] = $signed(in_bus.world_z);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          m_r[r][c] <= $signed(rot_r[r][59-20*c -: 20]) * pt[c];
        end
      end
    end
  end

  // stage 1: sum and round to camera coordinates
  logic signed [55:0] acc [3];
  logic signed [55:0] rnd [3];
  logic signed [CW-1:0] cam_r [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 56'(m_r[r][0]) + 56'(m_r[r][1]) + 56'(m_r[r][2])
             + (56'($signed(sh_r[r])) <<< ROT_FRAC);
      rnd[r] = acc[r] + 56'sd131072;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        cam_r[r] <= rnd[r][ROT_FRAC+CW-1:ROT_FRAC];
      end
    end
  end

  // stage 2: focal products
  prj_t          pu_r, pv_r;
  logic [CW-1:0] d2_r;
  logic          f2_r;
  logic [CW-1:0] mag_u, mag_v;

  assign mag_u = cam_r[0][CW-1] ? CW'(-cam_r[0]) : CW'(cam_r[0]);
  assign mag_v = cam_r[1][CW-1] ? CW'(-cam_r[1]) : CW'(cam_r[1]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pu_r.prod <= PW'(focal_r[63:32]) * PW'(mag_u);
      pu_r.neg  <= cam_r[0][CW-1];
      pu_r.c    <= center_r[63:32];
      pv_r.prod <= PW'(focal_r[31:0]) * PW'(mag_v);
      pv_r.neg  <= cam_r[1][CW-1];
      pv_r.c    <= center_r[31:0];
      d2_r      <= cam_r[2];
      f2_r      <= !cam_r[2][CW-1] && (cam_r[2] != '0);
    end
  end

  // stage 3: overflow check and divider load
  div_t init_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      init_r.u     <= div_init(pu_r, d2_r);
      init_r.v     <= div_init(pv_r, d2_r);
      init_r.d     <= d2_r;
      init_r.front <= f2_r;
    end
  end

  // divider stages
  div_t div_r [NDIV];

  always_ff @(posedge clk) begin
    for (int j = 0; j < NDIV; j++) begin
      if (en[4+j]) begin
        if (j == 0) begin
          div_r[j].u <= div_steps(init_r.u, init_r.d);
          div_r[j].v <= div_steps(init_r.v, init_r.d);
          div_r[j].d <= init_r.d;
          div_r[j].front <= init_r.front;
        end else begin
          div_r[j].u <= div_steps(div_r[j-1].u, div_r[j-1].d);
          div_r[j].v <= div_steps(div_r[j-1].v, div_r[j-1].d);
          div_r[j].d <= div_r[j-1].d;
          div_r[j].front <= div_r[j-1].front;
        end
      end
    end
  end

  // output stage
  logic [32:0] fu, fv;
  logic        front_l;
  logic [31:0] u_r, v_r_pix;
  logic        front_r, clip_r;

  assign fu      = finish(div_r[NDIV-1].u);
  assign fv      = finish(div_r[NDIV-1].v);
  assign front_l = div_r[NDIV-1].front;

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      u_r     <= front_l ? fu[31:0] : 32'h0;
      v_r_pix <= front_l ? fv[31:0] : 32'h0;
      front_r <= front_l;
      clip_r  <= front_l && (fu[32] || fv[32]);
    end
  end

  assign out_bus.valid    = v_r[NST-1];
  assign out_bus.pixel_u  = u_r;
  assign out_bus.pixel_v  = v_r_pix;
  assign out_bus.in_front = front_r;
  assign out_bus.clipped  = clip_r;

`ifndef SYNTH
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.in_front |->
      out_bus.pixel_u == 32'h0 && out_bus.pixel_v == 32'h0 && !out_bus.clipped)
    else $error("point behind camera gave nonzero result");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid && !out_bus.ready)
    else $error("input held off without output stall");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.clipped |->
      out_bus.pixel_u == 32'h7fff_ffff || out_bus.pixel_u == 32'h8000_0000 ||
      out_bus.pixel_v == 32'h7fff_ffff || out_bus.pixel_v == 32'h8000_0000)
    else $error("clipped flag without saturated pixel");
`endif

endmodule
